@@ src/serial_command_frame_decoder_top_assert.svh @@
// Assertion macros for the serial command frame decoder checker.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef SERIAL_COMMAND_FRAME_DECODER_TOP_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define SCFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/scfd_pkg.sv @@
// Shared types and constants for the serial command frame decoder.
// No dependencies.
package scfd_pkg;

    localparam logic [7:0] SYNC_CR   = 8'h0D;
    localparam logic [7:0] SYNC_LF   = 8'h0A;
    localparam logic [7:0] CMD_MODE  = 8'hC1;
    localparam logic [7:0] CMD_ERROR = 8'hEB;
    localparam logic [3:0] MOTOR_MIN = 4'd1;
    localparam logic [3:0] MOTOR_MAX = 4'd8;
    localparam logic [3:0] ID_DC     = 4'hD;
    localparam logic [3:0] ID_E      = 4'hE;

    // low nibble command codes
    localparam logic [3:0] OP_CONNECT = 4'h0;
    localparam logic [3:0] OP_MODE    = 4'h1;
    localparam logic [3:0] OP_KP      = 4'h2;
    localparam logic [3:0] OP_KI      = 4'h3;
    localparam logic [3:0] OP_KD      = 4'h4;
    localparam logic [3:0] OP_TTV     = 4'h5;
    localparam logic [3:0] OP_DIA     = 4'h7;
    localparam logic [3:0] OP_DM      = 4'h8;
    localparam logic [3:0] OP_L0      = 4'h9;
    localparam logic [3:0] OP_ERROR   = 4'hB;
    localparam logic [3:0] OP_ANGLE   = 4'hC;
    localparam logic [3:0] OP_TENSION = 4'hF;

    // decoded kinds
    localparam logic [3:0] KIND_CONNECT = 4'd0;
    localparam logic [3:0] KIND_MODE    = 4'd1;
    localparam logic [3:0] KIND_KP      = 4'd2;
    localparam logic [3:0] KIND_KI      = 4'd3;
    localparam logic [3:0] KIND_KD      = 4'd4;
    localparam logic [3:0] KIND_TTV     = 4'd5;
    localparam logic [3:0] KIND_DIA     = 4'd6;
    localparam logic [3:0] KIND_DM      = 4'd7;
    localparam logic [3:0] KIND_L0      = 4'd8;
    localparam logic [3:0] KIND_DC      = 4'd9;
    localparam logic [3:0] KIND_E       = 4'd10;
    localparam logic [3:0] KIND_ERROR   = 4'd11;
    localparam logic [3:0] KIND_ANGLE   = 4'd12;
    localparam logic [3:0] KIND_TENSION = 4'd13;
    localparam logic [3:0] KIND_IGNORED = 4'd14;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SEEN_CR = 3'd1,
        PH_CMD     = 3'd2,
        PH_PAY0    = 3'd3,
        PH_PAY1    = 3'd4,
        PH_PAY2    = 3'd5,
        PH_PAY3    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [31:0] word;
    } frame_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [3:0]         motor_id;
        logic signed [31:0] raw_value;
        logic [7:0]         error_source;
        logic [7:0]         error_number;
        logic               set_complete;
        logic               reply_request;
        logic [7:0]         reply_byte;
    } result_t;

endpackage

@@ src/scfd_parser.sv @@
// Sync hunt and frame assembly: bytes in, one frame register out.
// Depends on scfd_pkg.
module scfd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                frm_valid,
    input  logic                frm_ready,
    output scfd_pkg::frame_t    frm
);
    import scfd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [23:0] pay_reg, pay_next;
    logic        frm_valid_reg, frm_valid_next;
    frame_t      frm_reg, frm_next;
    logic        accept;

    assign s_ready   = !frm_valid_reg || frm_ready;
    assign accept    = s_valid && s_ready;
    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

    always_comb begin
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        pay_next       = pay_reg;
        frm_next       = frm_reg;
        frm_valid_next = frm_valid_reg && !frm_ready;
        if (accept) begin
            case (phase_reg)
                PH_SEEN_CR: begin
                    if (s_rx_byte == SYNC_LF) begin
                        phase_next = PH_CMD;
                    end else if (s_rx_byte == SYNC_CR) begin
                        phase_next = PH_SEEN_CR;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_CMD: begin
                    cmd_next   = s_rx_byte;
                    pay_next   = '0;
                    phase_next = PH_PAY0;
                end
                PH_PAY0: begin
                    pay_next[7:0] = s_rx_byte;
                    phase_next    = PH_PAY1;
                end
                PH_PAY1: begin
                    pay_next[15:8] = s_rx_byte;
                    phase_next     = PH_PAY2;
                end
                PH_PAY2: begin
                    pay_next[23:16] = s_rx_byte;
                    phase_next      = PH_PAY3;
                end
                PH_PAY3: begin
                    frm_next.cmd   = cmd_reg;
                    frm_next.word  = {s_rx_byte, pay_reg};
                    frm_valid_next = 1'b1;
                    phase_next     = PH_HUNT;
                end
                default: begin
                    // hunting, and unused codes act as hunting
                    phase_next = (s_rx_byte == SYNC_CR) ? PH_SEEN_CR : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            cmd_reg       <= '0;
            pay_reg       <= '0;
            frm_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            pay_reg       <= pay_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frm_reg <= frm_next;
    end

endmodule

@@ src/scfd_decode.sv @@
// Command decode of one assembled frame into the result register.
// Depends on scfd_pkg.
module scfd_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                frm_valid,
    output logic                frm_ready,
    input  scfd_pkg::frame_t    frm,
    input  logic [7:0]          reply_status,
    output logic                res_valid,
    input  logic                res_ready,
    output scfd_pkg::result_t   res
);
    import scfd_pkg::*;

    logic    res_valid_reg, res_valid_next;
    result_t res_reg, res_next, dec;
    logic [3:0] lo, id;
    logic    motor_ok;

    assign lo       = frm.cmd[3:0];
    assign id       = frm.cmd[7:4];
    assign motor_ok = id inside {[MOTOR_MIN:MOTOR_MAX]};

    always_comb begin
        dec               = '0;
        dec.kind          = KIND_IGNORED;
        dec.motor_id      = id;
        dec.raw_value     = frm.word;
        case (lo)
            OP_CONNECT: begin
                dec.kind          = KIND_CONNECT;
                dec.reply_request = 1'b1;
                dec.reply_byte    = reply_status;
            end
            OP_MODE: begin
                if (frm.cmd == CMD_MODE) begin
                    dec.kind = KIND_MODE;
                end
            end
            OP_KP:      if (motor_ok) dec.kind = KIND_KP;
            OP_KI:      if (motor_ok) dec.kind = KIND_KI;
            OP_KD, OP_TTV, OP_DIA, OP_DM: begin
                if (motor_ok) begin
                    dec.set_complete = (id == MOTOR_MAX);
                    case (lo)
                        OP_KD:   dec.kind = KIND_KD;
                        OP_TTV:  dec.kind = KIND_TTV;
                        OP_DIA:  dec.kind = KIND_DIA;
                        default: dec.kind = KIND_DM;
                    endcase
                end
            end
            OP_L0: begin
                if (motor_ok) begin
                    dec.kind = KIND_L0;
                end else if (id == ID_DC) begin
                    dec.kind         = KIND_DC;
                    dec.set_complete = 1'b1;
                end else if (id == ID_E) begin
                    dec.kind         = KIND_E;
                    dec.set_complete = 1'b1;
                end
            end
            OP_ERROR: begin
                if (frm.cmd == CMD_ERROR) begin
                    dec.kind         = KIND_ERROR;
                    dec.error_source = frm.word[7:0];
                    dec.error_number = frm.word[15:8];
                end
            end
            OP_ANGLE:   if (motor_ok) dec.kind = KIND_ANGLE;
            OP_TENSION: if (motor_ok) dec.kind = KIND_TENSION;
            default: ;
        endcase
    end

    assign frm_ready = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (frm_ready) begin
            res_valid_next = frm_valid;
            res_next       = dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

@@ src/serial_command_frame_decoder_top.sv @@
// Serial command frame decoder, top level.
// Depends on scfd_pkg, scfd_parser and scfd_decode.
//
// Usage:
//   s_ channel: one received byte per item (s_rx_byte), valid/ready.
//   m_ channel: one decoded record per complete frame, valid/ready.
//   cfg_we/cfg_wdata: writes the reply status byte; write only when idle.
// Frames are 0D 0A, a command byte, then a 4-byte little-endian payload.
// Only the last payload byte yields a record; all other bytes give none.
// Throughput: one byte per cycle, sustained, when m_ready stays high.
// The last byte of a frame passes the frame register, then the result
// register, and the record is valid from there; it can go at the next edge.
// Stall: with m_ready low the result register holds, one more frame may
// wait in the frame register, and s_ready drops only when both are full.
// Reset (aresetn low, synchronous): sync hunt restarts, both registers
// empty, reply status clears to zero.
module serial_command_frame_decoder_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_kind,
    output logic [3:0]         m_motor_id,
    output logic signed [31:0] m_raw_value,
    output logic [7:0]         m_error_source,
    output logic [7:0]         m_error_number,
    output logic               m_set_complete,
    output logic               m_reply_request,
    output logic [7:0]         m_reply_byte
);
    import scfd_pkg::*;

    logic [7:0] status_reg;
    logic       frm_valid, frm_ready;
    frame_t     frm;
    result_t    res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= '0;
        end else if (cfg_we) begin
            status_reg <= cfg_wdata;
        end
    end

    scfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm)
    );

    scfd_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frm_valid    (frm_valid),
        .frm_ready    (frm_ready),
        .frm          (frm),
        .reply_status (status_reg),
        .res_valid    (m_valid),
        .res_ready    (m_ready),
        .res          (res)
    );

    assign m_kind          = res.kind;
    assign m_motor_id      = res.motor_id;
    assign m_raw_value     = res.raw_value;
    assign m_error_source  = res.error_source;
    assign m_error_number  = res.error_number;
    assign m_set_complete  = res.set_complete;
    assign m_reply_request = res.reply_request;
    assign m_reply_byte    = res.reply_byte;

endmodule

@@ src/scfd_checker.sv @@
// Port-level checks for the serial command frame decoder, bound to the top.
// Depends on scfd_pkg and serial_command_frame_decoder_top_assert.svh.
`include "serial_command_frame_decoder_top_assert.svh"

module scfd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_we,
    input logic [7:0]         cfg_wdata,
    input logic               s_valid,
    input logic               s_ready,
    input logic [7:0]         s_rx_byte,
    input logic               m_valid,
    input logic               m_ready,
    input logic [3:0]         m_kind,
    input logic [3:0]         m_motor_id,
    input logic signed [31:0] m_raw_value,
    input logic [7:0]         m_error_source,
    input logic [7:0]         m_error_number,
    input logic               m_set_complete,
    input logic               m_reply_request,
    input logic [7:0]         m_reply_byte
);
    import scfd_pkg::*;

    `SCFD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_kind) && $stable(m_raw_value),
        "stalled item changed")

    `SCFD_ASSERT_NOW(a_reply_connect, m_valid,
        m_reply_request == (m_kind == KIND_CONNECT),
        "reply request does not match connect kind")

    `SCFD_ASSERT_NOW(a_error_fields, m_valid && (m_kind != KIND_ERROR),
        (m_error_source == 8'd0) && (m_error_number == 8'd0),
        "error fields set on non-error item")

    `SCFD_ASSERT_NOW(a_set_done, m_valid && ((m_kind == KIND_DC) || (m_kind == KIND_E)),
        m_set_complete, "dc or e without set complete")

endmodule

bind serial_command_frame_decoder_top scfd_checker u_scfd_checker (.*);
